// ===== design/assert_macros.svh =====
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an expression at every clock edge outside reset
`define RSA_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent
`define RSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rsa_pkg.sv =====
// Types and constants of the ring slot allocator
`timescale 1ns / 1ps
package rsa_pkg;

    localparam int SLOT_W  = 6;
    localparam int CNT_W   = 7;
    localparam int BYTES_W = 17;
    localparam int ADDR_W  = 32;
    localparam int PROD_W  = SLOT_W + BYTES_W;

    localparam logic [CNT_W-1:0]   RST_SLOTS   = 7'd64;
    localparam logic [BYTES_W-1:0] RST_BYTES   = 17'd4096;
    localparam logic [CNT_W-1:0]   INFLIGHT_MAX = 7'd64;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_REG   = 2'd1,
        CMD_DONE  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        CFG_SLOTS = 2'd0,
        CFG_BYTES = 2'd1,
        CFG_BASE  = 2'd2,
        CFG_SPARE = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_RECOUNT
    } t_state;

    typedef struct packed {
        logic              load;
        logic              shift;
        logic [SLOT_W-1:0] start;
        logic              set;
        logic              clr;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  ring_n;
    } t_cell_ctl;

endpackage

// ===== design/rsa_cell.sv =====
// One ring slot: dirty bit and probe token stage
`timescale 1ns / 1ps
module rsa_cell #(
    parameter int IDX = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rsa_pkg::t_cell_ctl i_ctl,
    input  logic              i_probe,
    output logic              o_probe,
    output logic              o_wrap,
    output logic              o_probe_dirty,
    output logic              o_sel_dirty
);
    import rsa_pkg::*;

    logic r_dirty;
    logic r_probe;
    logic n_dirty;
    logic n_probe;
    logic w_sel;
    logic w_last;

    assign w_sel  = (i_ctl.slot == SLOT_W'(IDX));
    assign w_last = (i_ctl.ring_n == CNT_W'(IDX + 1));

    always_comb begin
        n_dirty = r_dirty;
        if (w_sel && i_ctl.set) begin
            n_dirty = 1'b1;
        end else if (w_sel && i_ctl.clr) begin
            n_dirty = 1'b0;
        end
        n_probe = r_probe;
        if (i_ctl.load) begin
            n_probe = (i_ctl.start == SLOT_W'(IDX));
        end else if (i_ctl.shift) begin
            n_probe = i_probe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dirty <= 1'b0;
            r_probe <= 1'b0;
        end else begin
            r_dirty <= n_dirty;
            r_probe <= n_probe;
        end
    end

    assign o_probe       = r_probe & ~w_last;
    assign o_wrap        = r_probe & w_last;
    assign o_probe_dirty = r_probe & r_dirty;
    assign o_sel_dirty   = w_sel & r_dirty;

endmodule

// ===== design/rsa_row.sv =====
// Row of slot cells with the probe ring and status gathering
`timescale 1ns / 1ps
module rsa_row #(
    parameter int DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rsa_pkg::t_cell_ctl i_ctl,
    output logic               o_probe_dirty,
    output logic               o_sel_dirty
);
    import rsa_pkg::*;

    logic [DEPTH-1:0] w_probe_out;
    logic [DEPTH-1:0] w_wrap;
    logic [DEPTH-1:0] w_probe_dirty;
    logic [DEPTH-1:0] w_sel_dirty;
    logic [DEPTH-1:0] w_probe_in;

    assign w_probe_in[0] = |w_wrap;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g > 0) begin : g_link
            assign w_probe_in[g] = w_probe_out[g-1];
        end
        rsa_cell #(
            .IDX(g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (i_ctl),
            .i_probe      (w_probe_in[g]),
            .o_probe      (w_probe_out[g]),
            .o_wrap       (w_wrap[g]),
            .o_probe_dirty(w_probe_dirty[g]),
            .o_sel_dirty  (w_sel_dirty[g])
        );
    end

    assign o_probe_dirty = |w_probe_dirty;
    assign o_sel_dirty   = |w_sel_dirty;

endmodule

// ===== design/ring_slot_allocator.sv =====
// Ring slot allocator: next-fit slot grants over a ring of send buffers
//
// Register, complete and unused requests finish in the cycle they are taken,
// so their result is offered in the next cycle. An allocate request loads a
// probe token at the head cell of the slot chain; the token steps one cell
// per clock until it meets a clean slot or has tried every slot of the ring,
// which reports the ring full. Writing slots_in_use starts a recount pass
// that walks the token over all cells of the ring, during which neither
// requests nor further register writes are taken. One request is in work at
// a time; a request is taken only while the output register is empty or is
// being emptied in the same cycle, and a register write takes priority over
// a request offered in the same cycle.
`timescale 1ns / 1ps
module ring_slot_allocator #(
    parameter int MAX_SLOTS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_cmd,
    input  logic [rsa_pkg::SLOT_W-1:0]  i_slot,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [rsa_pkg::SLOT_W-1:0]  o_granted_slot,
    output logic [rsa_pkg::ADDR_W-1:0]  o_granted_address,
    output logic                        o_full_res,
    output logic                        o_accepted,
    output logic [rsa_pkg::CNT_W-1:0]   o_free_count,
    output logic [rsa_pkg::CNT_W-1:0]   o_dirty_count,
    output logic [rsa_pkg::CNT_W-1:0]   o_peak_dirty,
    output logic [rsa_pkg::ADDR_W-1:0]  o_allocation_count,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [1:0]                  i_cfg_index,
    input  logic [rsa_pkg::ADDR_W-1:0]  i_cfg_data
);
    import rsa_pkg::*;

    localparam int DEPTH = (MAX_SLOTS < 64) ? MAX_SLOTS : 64;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    t_state              r_state,  n_state;
    logic [CNT_W-1:0]    r_slots,  n_slots;
    logic [BYTES_W-1:0]  r_bytes,  n_bytes;
    logic [ADDR_W-1:0]   r_base,   n_base;
    logic [SLOT_W-1:0]   r_head,   n_head;
    logic [CNT_W-1:0]    r_free,   n_free;
    logic [CNT_W-1:0]    r_infl,   n_infl;
    logic [CNT_W-1:0]    r_peak,   n_peak;
    logic [ADDR_W-1:0]   r_total,  n_total;
    logic [SLOT_W-1:0]   r_pos,    n_pos;
    logic [CNT_W-1:0]    r_step,   n_step;
    logic [CNT_W-1:0]    r_sum,    n_sum;

    logic                r_out_valid, n_out_valid;
    logic [SLOT_W-1:0]   r_gslot,  n_gslot;
    logic [ADDR_W-1:0]   r_gaddr,  n_gaddr;
    logic                r_full,   n_full;
    logic                r_acc,    n_acc;
    logic [CNT_W-1:0]    r_free_o, n_free_o;
    logic [CNT_W-1:0]    r_infl_o, n_infl_o;
    logic [CNT_W-1:0]    r_peak_o, n_peak_o;
    logic [ADDR_W-1:0]   r_total_o, n_total_o;

    t_cell_ctl           w_ctl;
    logic                w_probe_dirty;
    logic                w_sel_dirty;
    logic [CNT_W-1:0]    w_ring_n;
    logic [SLOT_W-1:0]   w_start;
    logic                w_out_free;
    logic                w_in_ready;
    logic                w_cfg_ready;
    logic [SLOT_W-1:0]   w_calc_slot;
    logic [PROD_W-1:0]   w_prod;
    logic [ADDR_W-1:0]   w_addr;
    logic [CNT_W-1:0]    w_pos_inc;
    logic [CNT_W-1:0]    w_step_inc;
    logic [CNT_W-1:0]    w_sum_inc;

    assign w_ring_n   = (r_slots == '0) ? CNT_W'(1) :
                        ((r_slots > DEPTH_C) ? DEPTH_C : r_slots);
    assign w_start    = (CNT_W'(r_head) < w_ring_n) ? r_head : '0;
    assign w_out_free = ~r_out_valid | i_out_ready;
    assign w_pos_inc  = CNT_W'(r_pos) + CNT_W'(1);
    assign w_step_inc = r_step + CNT_W'(1);
    assign w_sum_inc  = r_sum + CNT_W'(w_probe_dirty);
    assign w_calc_slot = (r_state == ST_SEARCH) ? r_pos : i_slot;
    assign w_prod     = PROD_W'(w_calc_slot) * PROD_W'(r_bytes);
    assign w_addr     = r_base + ADDR_W'(w_prod);

    rsa_row #(
        .DEPTH(DEPTH)
    ) u_row (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .o_probe_dirty(w_probe_dirty),
        .o_sel_dirty  (w_sel_dirty)
    );

    always_comb begin
        n_state     = r_state;
        n_slots     = r_slots;
        n_bytes     = r_bytes;
        n_base      = r_base;
        n_head      = r_head;
        n_free      = r_free;
        n_infl      = r_infl;
        n_peak      = r_peak;
        n_total     = r_total;
        n_pos       = r_pos;
        n_step      = r_step;
        n_sum       = r_sum;
        n_out_valid = r_out_valid & ~i_out_ready;
        n_gslot     = r_gslot;
        n_gaddr     = r_gaddr;
        n_full      = r_full;
        n_acc       = r_acc;
        n_free_o    = r_free_o;
        n_infl_o    = r_infl_o;
        n_peak_o    = r_peak_o;
        n_total_o   = r_total_o;
        w_in_ready  = 1'b0;
        w_cfg_ready = 1'b0;
        w_ctl        = '0;
        w_ctl.ring_n = w_ring_n;
        w_ctl.slot   = i_slot;
        w_ctl.start  = w_start;

        case (r_state)
            ST_IDLE: begin
                w_cfg_ready = 1'b1;
                w_in_ready  = w_out_free & ~i_cfg_valid;
                if (i_cfg_valid) begin
                    case (i_cfg_index)
                        CFG_SLOTS: begin
                            n_slots     = i_cfg_data[CNT_W-1:0];
                            w_ctl.load  = 1'b1;
                            w_ctl.start = '0;
                            n_step      = '0;
                            n_sum       = '0;
                            n_state     = ST_RECOUNT;
                        end
                        CFG_BYTES: n_bytes = i_cfg_data[BYTES_W-1:0];
                        CFG_BASE:  n_base  = i_cfg_data;
                        default:   n_base  = r_base;
                    endcase
                end else if (i_in_valid && w_out_free) begin
                    if (i_cmd == CMD_ALLOC) begin
                        w_ctl.load = 1'b1;
                        n_pos      = w_start;
                        n_step     = '0;
                        n_state    = ST_SEARCH;
                    end else begin
                        n_acc = 1'b0;
                        case (i_cmd)
                            CMD_REG: begin
                                if (CNT_W'(i_slot) < w_ring_n && !w_sel_dirty) begin
                                    w_ctl.set = 1'b1;
                                    n_acc     = 1'b1;
                                    if (r_free != '0) begin
                                        n_free = r_free - CNT_W'(1);
                                    end
                                    if (r_infl < INFLIGHT_MAX) begin
                                        n_infl = r_infl + CNT_W'(1);
                                    end
                                    if (n_infl > r_peak) begin
                                        n_peak = n_infl;
                                    end
                                end
                            end
                            CMD_DONE: begin
                                if (CNT_W'(i_slot) < DEPTH_C && w_sel_dirty) begin
                                    w_ctl.clr = 1'b1;
                                    n_acc     = 1'b1;
                                    if (CNT_W'(i_slot) < w_ring_n && r_free < w_ring_n) begin
                                        n_free = r_free + CNT_W'(1);
                                    end
                                    if (r_infl != '0) begin
                                        n_infl = r_infl - CNT_W'(1);
                                    end
                                end
                            end
                            default: n_acc = 1'b0;
                        endcase
                        n_out_valid = 1'b1;
                        n_gslot     = i_slot;
                        n_gaddr     = w_addr;
                        n_full      = 1'b0;
                        n_free_o    = n_free;
                        n_infl_o    = n_infl;
                        n_peak_o    = n_peak;
                        n_total_o   = r_total;
                    end
                end
            end
            ST_SEARCH: begin
                if (!w_probe_dirty || w_step_inc == w_ring_n) begin
                    if (w_out_free) begin
                        n_total     = r_total + ADDR_W'(1);
                        n_out_valid = 1'b1;
                        n_free_o    = r_free;
                        n_infl_o    = r_infl;
                        n_peak_o    = r_peak;
                        n_total_o   = n_total;
                        n_state     = ST_IDLE;
                        if (!w_probe_dirty) begin
                            n_gslot = r_pos;
                            n_gaddr = w_addr;
                            n_full  = 1'b0;
                            n_acc   = 1'b1;
                            n_head  = (w_pos_inc == w_ring_n) ? '0 : w_pos_inc[SLOT_W-1:0];
                        end else begin
                            n_gslot = '0;
                            n_gaddr = '0;
                            n_full  = 1'b1;
                            n_acc   = 1'b0;
                        end
                    end
                end else begin
                    w_ctl.shift = 1'b1;
                    n_step      = w_step_inc;
                    n_pos       = (w_pos_inc == w_ring_n) ? '0 : w_pos_inc[SLOT_W-1:0];
                end
            end
            ST_RECOUNT: begin
                if (w_step_inc == w_ring_n) begin
                    n_free  = w_ring_n - w_sum_inc;
                    n_state = ST_IDLE;
                end else begin
                    w_ctl.shift = 1'b1;
                    n_step      = w_step_inc;
                    n_sum       = w_sum_inc;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_slots     <= RST_SLOTS;
            r_bytes     <= RST_BYTES;
            r_base      <= '0;
            r_head      <= '0;
            r_free      <= DEPTH_C;
            r_infl      <= '0;
            r_peak      <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_slots     <= n_slots;
            r_bytes     <= n_bytes;
            r_base      <= n_base;
            r_head      <= n_head;
            r_free      <= n_free;
            r_infl      <= n_infl;
            r_peak      <= n_peak;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_step    <= n_step;
        r_sum     <= n_sum;
        r_gslot   <= n_gslot;
        r_gaddr   <= n_gaddr;
        r_full    <= n_full;
        r_acc     <= n_acc;
        r_free_o  <= n_free_o;
        r_infl_o  <= n_infl_o;
        r_peak_o  <= n_peak_o;
        r_total_o <= n_total_o;
    end

    assign o_in_ready         = w_in_ready;
    assign o_cfg_ready        = w_cfg_ready;
    assign o_out_valid        = r_out_valid;
    assign o_granted_slot     = r_gslot;
    assign o_granted_address  = r_gaddr;
    assign o_full_res         = r_full;
    assign o_accepted         = r_acc;
    assign o_free_count       = r_free_o;
    assign o_dirty_count      = r_infl_o;
    assign o_peak_dirty       = r_peak_o;
    assign o_allocation_count = r_total_o;

endmodule

// ===== design/rsa_checker.sv =====
// Port-level checks for the ring slot allocator, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rsa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [5:0]  o_granted_slot,
    input logic [31:0] o_granted_address,
    input logic        o_full_res,
    input logic        o_accepted,
    input logic [6:0]  o_dirty_count,
    input logic [6:0]  o_peak_dirty
);

    `RSA_ASSERT_ALWAYS(a_full_not_acc, !o_out_valid || !(o_full_res && o_accepted), "full request reported as accepted")

    `RSA_ASSERT_ALWAYS(a_full_zero, !(o_out_valid && o_full_res) || (o_granted_slot == 6'd0 && o_granted_address == 32'd0), "full request carries a slot or address")

    `RSA_ASSERT_ALWAYS(a_peak_bound, !o_out_valid || (o_dirty_count <= o_peak_dirty), "in-flight count above its peak")

    `RSA_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_granted_slot) && $stable(o_granted_address), "stalled result changed")

endmodule

bind ring_slot_allocator rsa_checker u_rsa_checker (.*);
